### rtl/bup_pkg.sv
// ----------------------------------------------------------------------------
// bup_pkg
// Shared types and constants of the bilinear upscaler.
// ----------------------------------------------------------------------------
`default_nettype none
package bup_pkg;
  localparam int unsigned CFG_ADDR_BITS = 5;

  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CHANNELS   = 3'd2;
  localparam logic [2:0] REG_SCALE      = 3'd3;
  localparam logic [2:0] REG_LIMIT      = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_CHAN  = 3'd1;
  localparam logic [2:0] ST_BAD_SCALE = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE = 3'd3;
  localparam logic [2:0] ST_BAD_COORD = 3'd4;

  localparam int unsigned SMP_W = 16;

  typedef struct packed {
    logic [7:0]  src_width;
    logic [7:0]  src_height;
    logic [2:0]  channel_count;
    logic [2:0]  scale_factor;
    logic [18:0] output_pixel_limit;
  } cfg_t;

  typedef struct packed {
    logic             mode;
    logic [8:0]       pos_x;
    logic [8:0]       pos_y;
    logic [SMP_W-1:0] in_ch0;
    logic [SMP_W-1:0] in_ch1;
    logic [SMP_W-1:0] in_ch2;
    logic [SMP_W-1:0] in_ch3;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [SMP_W-1:0] out_ch0;
    logic [SMP_W-1:0] out_ch1;
    logic [SMP_W-1:0] out_ch2;
    logic [SMP_W-1:0] out_ch3;
  } out_item_t;
endpackage
`default_nettype wire

### rtl/bup_stream_if.sv
// ----------------------------------------------------------------------------
// bup_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface bup_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/bup_ram.sv
// ----------------------------------------------------------------------------
// bup_ram
// Simple dual-port RAM with registered read and read enable.
// ----------------------------------------------------------------------------
`default_nettype none
module bup_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

### rtl/bup_lerp.sv
// ----------------------------------------------------------------------------
// bup_lerp
// Weighted sum of four samples in one registered step, enable-gated.
// ----------------------------------------------------------------------------
`default_nettype none
module bup_lerp #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [SAMPLE_BITS-1:0] v0,
  input  wire logic [SAMPLE_BITS-1:0] v1,
  input  wire logic [SAMPLE_BITS-1:0] v2,
  input  wire logic [SAMPLE_BITS-1:0] v3,
  input  wire logic [3:0]             tx,
  input  wire logic [3:0]             ty,
  output logic      [SAMPLE_BITS-1:0] val
);
  localparam int SW = SAMPLE_BITS + 7;
  logic [6:0]  w0, w1, w2, w3;
  logic [SW-1:0] sum;

  always_comb begin
    w0 = 7'((4'd8 - tx) * (4'd8 - ty));
    w1 = 7'(tx * (4'd8 - ty));
    w2 = 7'((4'd8 - tx) * ty);
    w3 = 7'(tx * ty);
    sum = SW'(v0) * SW'(w0) + SW'(v1) * SW'(w1) + SW'(v2) * SW'(w2)
        + SW'(v3) * SW'(w3) + SW'(32);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val <= sum[SW-2:6];
    end
  end
endmodule
`default_nettype wire

### rtl/bilinear_upscaler_clamped.sv
// ----------------------------------------------------------------------------
// bilinear_upscaler_clamped
// Bilinear 2x/4x upscaler with neighbor and alpha clamping.
// ----------------------------------------------------------------------------
// One item per cycle while the output is not stalled. The pipeline has five
// stages (validate and map, four quad-banked store reads, interpolate, clamp,
// output register); the whole pipeline advances only when the output is free,
// so a stall holds every stage. The source store is four RAM banks split by
// column and row parity, so the four neighbors of a sample are read in the
// same cycle. Loads write in stage one and give no result. No clearing pass:
// reading an unloaded pixel is undefined.
`default_nettype none
module bilinear_upscaler_clamped #(
  parameter int MAX_WIDTH   = 128,
  parameter int MAX_HEIGHT  = 128,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  bup_stream_if.sink   in_ch,
  bup_stream_if.source out_ch,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bup_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready
);
  import bup_pkg::*;

  localparam int XB = $clog2(MAX_WIDTH);
  localparam int YB = $clog2(MAX_HEIGHT);
  localparam int BXB = (XB > 1) ? XB - 1 : 1;
  localparam int BYB = (YB > 1) ? YB - 1 : 1;
  localparam int BAB = BXB + BYB;
  localparam int BDEPTH = (1 << BAB);
  localparam int SB = SAMPLE_BITS;
  localparam int PW = 16;  // position in eighths, up to 8*254

  cfg_t cfg;
  logic [2:0] reg_idx;
  assign reg_idx = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{8'd1, 8'd1, 3'd1, 3'd2, 19'd262144};
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (reg_idx)
        REG_SRC_WIDTH:  cfg.src_width <= pwdata[7:0];
        REG_SRC_HEIGHT: cfg.src_height <= pwdata[7:0];
        REG_CHANNELS:   cfg.channel_count <= pwdata[2:0];
        REG_SCALE:      cfg.scale_factor <= pwdata[2:0];
        REG_LIMIT:      cfg.output_pixel_limit <= pwdata[18:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SRC_WIDTH:  prdata = {24'd0, cfg.src_width};
      REG_SRC_HEIGHT: prdata = {24'd0, cfg.src_height};
      REG_CHANNELS:   prdata = {29'd0, cfg.channel_count};
      REG_SCALE:      prdata = {29'd0, cfg.scale_factor};
      REG_LIMIT:      prdata = {13'd0, cfg.output_pixel_limit};
      default:        prdata = 32'd0;
    endcase
  end

  // Pipeline advance: whole pipe moves when output register is empty or taken.
  logic adv;
  logic v1, v2, v3, v4, v5;
  assign adv = !v5 || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = v5;

  // ---- stage 0 (combinational): checks and position mapping
  in_item_t it;
  logic [12:0] w, h;
  logic [14:0] ow, oh;
  logic [29:0] area;
  logic [2:0]  st0;
  logic        s4;
  logic [PW-1:0] sx, sy;
  assign it = in_ch.data;

  function automatic logic [PW-1:0] map_pos(input logic [8:0] o, input logic four,
                                             input logic [12:0] n);
    logic signed [PW+1:0] p;
    logic signed [PW+1:0] hi;
    p  = four ? $signed({8'd0, o, 1'b1}) - 4 : $signed({7'd0, o, 2'b10}) - 4;
    hi = $signed((PW+2)'({n - 13'd1, 3'b000}));
    if (p < 0) p = '0;
    if (p > hi) p = hi;
    return p[PW-1:0];
  endfunction

  always_comb begin
    w = (cfg.src_width == 8'd0) ? 13'd1 :
        ({5'd0, cfg.src_width} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {5'd0, cfg.src_width};
    h = (cfg.src_height == 8'd0) ? 13'd1 :
        ({5'd0, cfg.src_height} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : {5'd0, cfg.src_height};
    s4 = (cfg.scale_factor == 3'd4);
    ow = s4 ? {w, 2'b00} : {1'b0, w, 1'b0};
    oh = s4 ? {h, 2'b00} : {1'b0, h, 1'b0};
    area = 30'(ow) * 30'(oh);
    if (cfg.channel_count != 3'd1 && cfg.channel_count != 3'd3 && cfg.channel_count != 3'd4)
      st0 = ST_BAD_CHAN;
    else if ((cfg.scale_factor != 3'd2 && !s4) || cfg.output_pixel_limit == 19'd0)
      st0 = ST_BAD_SCALE;
    else if (area > 30'(cfg.output_pixel_limit))
      st0 = ST_TOO_LARGE;
    else if (15'(it.pos_x) >= ow || 15'(it.pos_y) >= oh)
      st0 = ST_BAD_COORD;
    else
      st0 = ST_OK;
    sx = map_pos(it.pos_x, s4, w);
    sy = map_pos(it.pos_y, s4, h);
  end

  // ---- stage 1 registers: fractions and neighbor bank selects
  logic [2:0]  st1;
  logic [12:0] x0, y0, x1, y1;
  logic [2:0]  tx1, ty1;
  always_comb begin
    x1 = (sx[PW-1:3] + 13'd1 < w) ? sx[PW-1:3] + 13'd1 : w - 13'd1;
    y1 = (sy[PW-1:3] + 13'd1 < h) ? sy[PW-1:3] + 13'd1 : h - 13'd1;
  end

  // Load write port
  logic ld_we;
  assign ld_we = in_ch.valid && adv && !it.mode &&
                 32'(it.pos_x) < MAX_WIDTH && 32'(it.pos_y) < MAX_HEIGHT;
  logic [4*SB-1:0] ld_word;
  assign ld_word = {it.in_ch3[SB-1:0], it.in_ch2[SB-1:0], it.in_ch1[SB-1:0],
                    it.in_ch0[SB-1:0]};

  // Bank b = {y parity, x parity}. Neighbor rows/cols x0,x1 differ by at most one.
  logic [12:0] cx [2];
  logic [12:0] cy [2];
  always_comb begin
    // column index used for even/odd banks
    cx[0] = sx[3] ? x1 : sx[PW-1:3];
    cx[1] = sx[3] ? sx[PW-1:3] : x1;
    cy[0] = sy[3] ? y1 : sy[PW-1:3];
    cy[1] = sy[3] ? sy[PW-1:3] : y1;
  end

  logic [4*SB-1:0] rd [4];
  logic            rd_en;
  assign rd_en = adv;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [BAB-1:0] wa, ra;
    logic bwe;
    assign bwe = ld_we && it.pos_x[0] == b[0] && it.pos_y[0] == b[1];
    assign wa = {BYB'(it.pos_y[8:1]), BXB'(it.pos_x[8:1])};
    assign ra = {BYB'(cy[b/2][12:1]), BXB'(cx[b%2][12:1])};
    bup_ram #(.WIDTH(4*SB), .DEPTH(BDEPTH)) u_ram (
      .clk(clk), .we(bwe), .waddr(wa), .wdata(ld_word),
      .re(rd_en), .raddr(ra), .rdata(rd[b])
    );
  end

  logic [2:0] chn1;
  logic [1:0] sel1 [4];  // bank for neighbor 00,10,01,11
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_ch.valid && it.mode;
    end
  end
  // A neighbor's bank follows the parity of its own row and column, which
  // also covers the edge where both neighbors are the same pixel.
  always_ff @(posedge clk) begin
    if (adv) begin
      st1  <= st0;
      tx1  <= sx[2:0];
      ty1  <= sy[2:0];
      chn1 <= cfg.channel_count;
      sel1[0] <= {y0[0], x0[0]};
      sel1[1] <= {y0[0], x1[0]};
      sel1[2] <= {y1[0], x0[0]};
      sel1[3] <= {y1[0], x1[0]};
    end
  end
  assign x0 = sx[PW-1:3];
  assign y0 = sy[PW-1:3];

  // ---- stage 2: neighbor samples registered
  logic [SB-1:0] nb [4][4];  // [neighbor][channel]
  logic [2:0] st2, chn2;
  logic [3:0] tx2, ty2;
  logic [SB-1:0] lo2 [4], hi2 [4];
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      st2 <= st1; chn2 <= chn1; tx2 <= {1'b0, tx1}; ty2 <= {1'b0, ty1};
      for (int n = 0; n < 4; n++) begin
        for (int c = 0; c < 4; c++) begin
          nb[n][c] <= rd[sel1[n]][c*SB +: SB];
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      lo2[c] = nb[0][c]; hi2[c] = nb[0][c];
      for (int n = 1; n < 4; n++) begin
        if (nb[n][c] < lo2[c]) lo2[c] = nb[n][c];
        if (nb[n][c] > hi2[c]) hi2[c] = nb[n][c];
      end
    end
  end

  // ---- stage 3: interpolation results
  logic [SB-1:0] iv3 [4];
  logic [SB-1:0] lo3 [4], hi3 [4];
  logic [2:0] st3, chn3;
  for (genvar c = 0; c < 4; c++) begin : g_lerp
    bup_lerp #(.SAMPLE_BITS(SB)) u_lerp (
      .clk(clk), .en(adv), .v0(nb[0][c]), .v1(nb[1][c]), .v2(nb[2][c]), .v3(nb[3][c]),
      .tx(tx2), .ty(ty2), .val(iv3[c])
    );
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      st3 <= st2; chn3 <= chn2;
      for (int c = 0; c < 4; c++) begin
        lo3[c] <= lo2[c]; hi3[c] <= hi2[c];
      end
    end
  end

  // ---- stage 4: neighbor clamp
  logic [SB-1:0] cv4 [4];
  logic [SB-1:0] alpha4;
  logic [2:0] st4, chn4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      st4 <= st3; chn4 <= chn3; alpha4 <= iv3[3];
      for (int c = 0; c < 4; c++) begin
        cv4[c] <= (iv3[c] < lo3[c]) ? lo3[c] : (iv3[c] > hi3[c]) ? hi3[c] : iv3[c];
      end
    end
  end

  // ---- stage 5: alpha clamp, channel masking, output register
  out_item_t res;
  logic [SB-1:0] f [4];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      f[c] = cv4[c];
      if (chn4 == 3'd4 && c < 3 && cv4[c] > alpha4) f[c] = alpha4;
      if (st4 != ST_OK || c >= int'(chn4)) f[c] = '0;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      res <= '{st4, SMP_W'(f[0]), SMP_W'(f[1]), SMP_W'(f[2]), SMP_W'(f[3])};
    end
  end
  assign out_ch.data = res;
endmodule
`default_nettype wire

### rtl/bup_checker.sv
// ----------------------------------------------------------------------------
// bup_checker
// Port-level checks of the upscaler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module bup_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [2:0]  status,
  input wire logic [15:0] out_ch0
);
  import bup_pkg::*;

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_ch0))
    else $error("stalled result changed");
  // Input is taken whenever the output is free.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("input blocked with empty output");
  // Status stays within its codes.
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_BAD_COORD) else $error("bad status code");
  // Error results carry a zero channel-0 sample.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> out_ch0 == 16'd0) else $error("error result not zero");
endmodule

bind bilinear_upscaler_clamped bup_checker u_bup_checker (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.data.status), .out_ch0(out_ch.data.out_ch0)
);
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bilinear 2x/4x upscaler. Each phase programs
// the registers over APB, loads the whole source image and then streams
// output pixel requests. Every compute result is checked against a local
// predictor of the interpolation, neighbor clamp and alpha clamp.
// ----------------------------------------------------------------------------
module tb_top;
  import bup_pkg::*;

  localparam int unsigned STORE_W = 128;
  localparam int unsigned STORE_H = 128;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bup_stream_if #(.payload_t(in_item_t))  in_if ();
  bup_stream_if #(.payload_t(out_item_t)) out_if ();

  bilinear_upscaler_clamped DUT (
    .clk(clk), .rst(rst), .in_ch(in_if), .out_ch(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the block's registers and source image.
  logic [7:0]  cur_width = 8'd1;
  logic [7:0]  cur_height = 8'd1;
  logic [2:0]  cur_chans = 3'd1;
  logic [2:0]  cur_scale = 3'd2;
  logic [18:0] cur_limit = 19'd262144;
  logic [63:0] pixel_mem [0:STORE_W*STORE_H-1];

  in_item_t  pending_px[$];
  out_item_t expected_px[$];
  int errors = 0;
  int checked = 0;
  int loads_done = 0;
  int phases_run = 0;
  int burst_left = 0;
  int gap_left = 0;
  int unsigned cyc = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned mx);
    if (v < 1) return 1;
    return (v > mx) ? mx : v;
  endfunction

  // Source position in eighths of a pixel, clamped to the image.
  function automatic int unsigned src_pos(input int unsigned o, input int unsigned s,
                                          input int unsigned n);
    int p;
    int hi;
    p = int'((4 / s) * (2 * o + 1)) - 4;
    hi = int'(8 * (n - 1));
    if (p < 0) p = 0;
    if (p > hi) p = hi;
    return p;
  endfunction

  function automatic int unsigned blend(input int unsigned v[4], input int unsigned tx,
                                        input int unsigned ty);
    int unsigned sum;
    sum = v[0] * (8 - tx) * (8 - ty) + v[1] * tx * (8 - ty)
        + v[2] * (8 - tx) * ty + v[3] * tx * ty;
    return (sum + 32) >> 6;
  endfunction

  function automatic int unsigned smp(input int unsigned x, input int unsigned y,
                                      input int unsigned c);
    return pixel_mem[y * STORE_W + x][16 * c +: 16];
  endfunction

  function automatic out_item_t upscale_pixel(input in_item_t it);
    out_item_t r;
    int unsigned w, h, s, ow, oh, sx, sy, x0, x1, y0, y1, tx, ty, alpha, lo, hi, val;
    int unsigned v[4];
    int unsigned res[4];
    r = '0;
    w = clamp_size(cur_width, STORE_W);
    h = clamp_size(cur_height, STORE_H);
    s = cur_scale;
    ow = w * s;
    oh = h * s;
    if (cur_chans != 3'd1 && cur_chans != 3'd3 && cur_chans != 3'd4) r.status = ST_BAD_CHAN;
    else if ((s != 2 && s != 4) || cur_limit == 0) r.status = ST_BAD_SCALE;
    else if (ow * oh > cur_limit) r.status = ST_TOO_LARGE;
    else if (it.pos_x >= ow || it.pos_y >= oh) r.status = ST_BAD_COORD;
    else r.status = ST_OK;
    if (r.status != ST_OK) return r;
    sx = src_pos(it.pos_x, s, w);
    sy = src_pos(it.pos_y, s, h);
    x0 = sx >> 3; tx = sx & 7;
    y0 = sy >> 3; ty = sy & 7;
    x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
    y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
    alpha = 0;
    res = '{0, 0, 0, 0};
    if (cur_chans == 3'd4) begin
      v = '{smp(x0, y0, 3), smp(x1, y0, 3), smp(x0, y1, 3), smp(x1, y1, 3)};
      alpha = blend(v, tx, ty);
    end
    for (int c = 0; c < cur_chans && c < 4; c++) begin
      v = '{smp(x0, y0, c), smp(x1, y0, c), smp(x0, y1, c), smp(x1, y1, c)};
      lo = v[0]; hi = v[0];
      for (int j = 1; j < 4; j++) begin
        if (v[j] < lo) lo = v[j];
        if (v[j] > hi) hi = v[j];
      end
      val = blend(v, tx, ty);
      if (val < lo) val = lo;
      if (val > hi) val = hi;
      // Premultiplied color can never exceed its alpha.
      if (cur_chans == 3'd4 && c < 3 && val > alpha) val = alpha;
      res[c] = val;
    end
    r.out_ch0 = res[0];
    r.out_ch1 = res[1];
    r.out_ch2 = res[2];
    r.out_ch3 = res[3];
    return r;
  endfunction

  // Input driver: bursts of random length with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        if (in_if.data.mode == 1'b0) begin
          if (in_if.data.pos_x < STORE_W && in_if.data.pos_y < STORE_H)
            pixel_mem[in_if.data.pos_y * STORE_W + in_if.data.pos_x] =
              {in_if.data.in_ch3, in_if.data.in_ch2, in_if.data.in_ch1, in_if.data.in_ch0};
          loads_done++;
        end else begin
          expected_px.push_back(upscale_pixel(in_if.data));
        end
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_px.size() > 0) begin
          in_if.data <= pending_px.pop_front();
          in_if.valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result side: free-flowing stretches alternate with random stalls.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst) out_if.ready <= 1'b0;
    else if (cyc[7]) out_if.ready <= ($urandom_range(0, 2) != 0);
    else if (cyc[6]) out_if.ready <= ($urandom_range(0, 7) != 0);
    else out_if.ready <= 1'b1;
  end

  always @(posedge clk) begin
    out_item_t got, want;
    if (!rst && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (expected_px.size() == 0) begin
        report($sformatf("unexpected result status=%0d", got.status));
      end else begin
        want = expected_px.pop_front();
        checked++;
        if (got.status !== want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.out_ch0 !== want.out_ch0)
          report($sformatf("ch0 %0h, want %0h", got.out_ch0, want.out_ch0));
        if (got.out_ch1 !== want.out_ch1)
          report($sformatf("ch1 %0h, want %0h", got.out_ch1, want.out_ch1));
        if (got.out_ch2 !== want.out_ch2)
          report($sformatf("ch2 %0h, want %0h", got.out_ch2, want.out_ch2));
        if (got.out_ch3 !== want.out_ch3)
          report($sformatf("ch3 %0h, want %0h", got.out_ch3, want.out_ch3));
      end
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_BITS'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_px.size() != 0 || in_if.valid || expected_px.size() != 0)
      @(posedge clk);
    // Loads carry no result and may still be in flight.
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_sample();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_load(input int unsigned x, input int unsigned y);
    in_item_t it;
    it.mode = 1'b0;
    it.pos_x = x;
    it.pos_y = y;
    it.in_ch0 = rnd_sample();
    it.in_ch1 = rnd_sample();
    it.in_ch2 = rnd_sample();
    it.in_ch3 = rnd_sample();
    pending_px.push_back(it);
  endtask

  task automatic push_px(input int unsigned x, input int unsigned y);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom});
    it.mode = 1'b1;
    it.pos_x = x;
    it.pos_y = y;
    pending_px.push_back(it);
  endtask

  // Program all registers, load the whole visible image, then stream requests.
  task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned ch,
                           input int unsigned s, input int unsigned lim, input int n_rand);
    int unsigned ew, eh, ow, oh, x, y;
    wait_idle();
    reg_write(REG_SRC_WIDTH, w);
    reg_write(REG_SRC_HEIGHT, h);
    reg_write(REG_CHANNELS, ch);
    reg_write(REG_SCALE, s);
    reg_write(REG_LIMIT, lim);
    cur_width = w;
    cur_height = h;
    cur_chans = ch;
    cur_scale = s;
    cur_limit = lim;
    phases_run++;
    ew = clamp_size(w & 8'hFF, STORE_W);
    eh = clamp_size(h & 8'hFF, STORE_H);
    for (int yy = 0; yy < eh; yy++)
      for (int xx = 0; xx < ew; xx++)
        push_load(xx, yy);
    ow = ew * ((s == 4) ? 4 : 2);
    oh = eh * ((s == 4) ? 4 : 2);
    for (int i = 0; i < n_rand; i++) begin
      case ($urandom_range(0, 19))
        0: begin
          // Load that lands outside the visible image or the store.
          x = $urandom_range(0, 511);
          y = (x < ew) ? $urandom_range(eh, 511) : $urandom_range(0, 511);
          push_load(x, y);
        end
        1: push_px($urandom_range(0, 511), $urandom_range(0, 511));
        2: push_px(ow - 1, oh - 1);
        3: push_px(0, 0);
        default: push_px($urandom_range(0, ow - 1), $urandom_range(0, oh - 1));
      endcase
    end
  endtask

  initial begin
    in_item_t it;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: premultiplied 3x2 image, corners and coordinate errors.
    run_phase(3, 2, 4, 2, 262144, 0);
    push_px(0, 0); push_px(5, 3); push_px(2, 1); push_px(3, 2);
    push_px(6, 0); push_px(0, 4); push_px(511, 511);
    push_load(200, 3); push_load(3, 511);
    run_phase(2, 2, 3, 4, 262144, 0);
    push_px(0, 0); push_px(7, 7); push_px(3, 4); push_px(8, 8);
    // Directed: every error status and the size saturation.
    run_phase(2, 2, 0, 2, 262144, 2);
    run_phase(2, 2, 7, 2, 262144, 2);
    run_phase(2, 2, 2, 2, 262144, 1);
    run_phase(2, 2, 3, 3, 262144, 1);
    run_phase(2, 2, 1, 2, 0, 1);
    run_phase(4, 4, 1, 4, 255, 1);
    run_phase(0, 0, 1, 2, 4, 2);
    run_phase(255, 1, 1, 2, 262144, 4);
    run_phase(1, 128, 4, 4, 262144, 4);

    // Random phases; mostly small images with an occasional full-span one.
    for (int p = 0; p < 5; p++) begin
      int unsigned w, h, ch, s, lim;
      case ($urandom_range(0, 5))
        0: begin w = 128; h = $urandom_range(1, 2); end
        1: begin w = $urandom_range(1, 2); h = 128; end
        default: begin w = $urandom_range(1, 8); h = $urandom_range(1, 8); end
      endcase
      ch = ($urandom_range(0, 2) == 0) ? 1 : (($urandom_range(0, 1) == 0) ? 3 : 4);
      s = ($urandom_range(0, 1) == 0) ? 2 : 4;
      lim = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 524287) : 262144;
      if (p == 4) lim = 524287;
      run_phase(w, h, ch, s, lim, 40);
    end

    wait_idle();
    $display("Checked %0d output pixels over %0d register settings, %0d loads.",
             checked, phases_run, loads_done);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
